// ===== src/assert_macros.svh =====
// Assertion macros for the shadow stack return checker.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property.
`define SSRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define SSRC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

// ===== src/ssrc_pkg.sv =====
// Shared constants, codes and types of the shadow stack return checker.
// No dependencies.
`default_nettype none

package ssrc_pkg;

  localparam int unsigned StackDepth   = 64;
  localparam int unsigned NumThreads   = 4;
  localparam int unsigned AddrBits     = 48;

  localparam int unsigned AddrFieldW   = 48;
  localparam int unsigned ThreadFieldW = 2;
  localparam int unsigned WinW         = 3;
  localparam int unsigned DepthW       = 2;
  localparam int unsigned TotalW       = 32;

  localparam logic [WinW-1:0] WinMax   = 3'd4;
  localparam logic [WinW-1:0] WinReset = 3'd4;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 3;

  localparam logic ActCall = 1'b0;
  localparam logic ActRet  = 1'b1;

  typedef enum logic [2:0] {
    ST_PUSH = 3'd0,
    ST_TOP  = 3'd1,
    ST_DEEP = 3'd2,
    ST_MISS = 3'd3,
    ST_OVF  = 3'd4
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [DepthW-1:0]   depth;
    logic                flagged;
    logic [TotalW-1:0]   total;
  } result_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== src/ssrc_stack_mem.sv =====
// Return address store: one write port, one read port, registered read data.
// Uses ssrc_pkg for the port control struct.
`default_nettype none

module ssrc_stack_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 48
) (
  input  wire                   clk_i,
  input  ssrc_pkg::mem_ctl_t    ctl_i,
  input  wire  [AW-1:0]         waddr_i,
  input  wire  [DW-1:0]         wdata_i,
  input  wire  [AW-1:0]         raddr_i,
  output logic [DW-1:0]         rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/ssrc_ctrl.sv =====
// Sequencer: per-thread fill/top pointers, mismatch flags and counter,
// stack memory read/compare/commit and the result register. Uses ssrc_pkg.
`default_nettype none

module ssrc_ctrl #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned NUM_THREADS = 4,
  parameter int unsigned STORE_W     = 48,
  parameter int unsigned MAW         = 8
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire                                action_i,
  input  wire  [ssrc_pkg::ThreadFieldW-1:0]  thread_i,
  input  wire  [STORE_W-1:0]                 address_i,
  input  wire  [ssrc_pkg::WinW-1:0]          win_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output ssrc_pkg::result_t                  result_o,
  output ssrc_pkg::mem_ctl_t                 mem_ctl_o,
  output logic [MAW-1:0]                     mem_waddr_o,
  output logic [STORE_W-1:0]                 mem_wdata_o,
  output logic [MAW-1:0]                     mem_raddr_o,
  input  wire  [STORE_W-1:0]                 mem_rdata_i
);

  localparam int unsigned TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned WW = ssrc_pkg::WinW;
  localparam int unsigned DW = ssrc_pkg::DepthW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  // slot n entries below top, on the ring
  function automatic logic [SW-1:0] ring_back(logic [SW-1:0] top, logic [WW-1:0] n);
    logic [SW:0] t;
    logic [SW:0] nn;
    t  = {1'b0, top};
    nn = (SW+1)'(n);
    if (t >= nn) begin
      return SW'(t - nn);
    end
    return SW'(t + (SW+1)'(STACK_DEPTH) - nn);
  endfunction

  state_e                    state_q, state_d;
  logic                      out_valid_q, out_valid_d;
  logic [ssrc_pkg::TotalW-1:0] total_q, total_d;
  logic [NUM_THREADS-1:0]    flag_q, flag_d;
  logic [FW-1:0]             fill_q [NUM_THREADS];
  logic [FW-1:0]             fill_d [NUM_THREADS];
  logic [SW-1:0]             top_q  [NUM_THREADS];
  logic [SW-1:0]             top_d  [NUM_THREADS];

  logic                      act_q, act_d;
  logic [TW-1:0]             thr_q, thr_d;
  logic [STORE_W-1:0]        addr_q, addr_d;
  logic [WW-1:0]             lim_q, lim_d;
  logic [DW-1:0]             cmp_q, cmp_d;
  logic                      found_q, found_d;
  ssrc_pkg::result_t         res_q, res_d;

  logic [4:0]                thr_ext;
  logic [TW-1:0]             thr_in;
  logic [FW-1:0]             fill_cur;
  logic [SW-1:0]             top_cur;
  logic [WW-1:0]             lim_w;
  logic [WW-1:0]             rd_n;
  logic [WW-1:0]             pops;
  logic [MAW-1:0]            base;
  logic                      commit;

  // thread number modulo NUM_THREADS (input is below 4)
  always_comb begin
    thr_ext = {3'b000, thread_i};
    if (NUM_THREADS == 1) begin
      thr_in = '0;
    end else if (thr_ext >= 5'(NUM_THREADS)) begin
      thr_in = TW'(thr_ext - 5'(NUM_THREADS));
    end else begin
      thr_in = TW'(thr_ext);
    end
  end

  assign fill_cur = fill_q[thr_q];
  assign top_cur  = top_q[thr_q];
  assign lim_w    = (fill_cur < FW'(win_i)) ? WW'(fill_cur) : win_i;
  assign pops     = {1'b0, cmp_q} + WW'(1);
  assign base     = MAW'(thr_q) * MAW'(STACK_DEPTH);
  assign commit   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    total_d     = total_q;
    flag_d      = flag_q;
    fill_d      = fill_q;
    top_d       = top_q;
    act_d       = act_q;
    thr_d       = thr_q;
    addr_d      = addr_q;
    lim_d       = lim_q;
    cmp_d       = cmp_q;
    found_d     = found_q;
    res_d       = res_q;
    mem_ctl_o   = '0;
    rd_n        = WW'(1);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          thr_d   = thr_in;
          addr_d  = address_i;
          state_d = S_READ;
        end
      end
      S_READ: begin
        lim_d        = lim_w;
        cmp_d        = '0;
        found_d      = 1'b0;
        mem_ctl_o.re = (act_q == ssrc_pkg::ActRet);
        if ((act_q == ssrc_pkg::ActCall) || (lim_w == '0)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // prefetch the next entry while comparing this one
        mem_ctl_o.re = 1'b1;
        rd_n = (cmp_q == DW'(3)) ? WW'(4) : ({1'b0, cmp_q} + WW'(2));
        if (mem_rdata_i == addr_q) begin
          found_d = 1'b1;
          state_d = S_DONE;
        end else if (pops == lim_q) begin
          state_d = S_DONE;
        end else begin
          cmp_d = cmp_q + DW'(1);
        end
      end
      S_DONE: begin
        if (commit) begin
          res_d.depth   = '0;
          res_d.flagged = flag_q[thr_q];
          res_d.total   = total_q;
          if (act_q == ssrc_pkg::ActCall) begin
            mem_ctl_o.we = 1'b1;
            top_d[thr_q] = (top_cur == SW'(STACK_DEPTH - 1)) ? '0 : top_cur + SW'(1);
            if (fill_cur == FW'(STACK_DEPTH)) begin
              res_d.status = ssrc_pkg::ST_OVF;
            end else begin
              fill_d[thr_q] = fill_cur + FW'(1);
              res_d.status  = ssrc_pkg::ST_PUSH;
            end
          end else if (found_q) begin
            fill_d[thr_q] = fill_cur - FW'(pops);
            top_d[thr_q]  = ring_back(top_cur, pops);
            res_d.depth   = cmp_q;
            res_d.status  = (cmp_q == '0) ? ssrc_pkg::ST_TOP : ssrc_pkg::ST_DEEP;
          end else begin
            flag_d[thr_q] = 1'b1;
            total_d       = (total_q == '1) ? total_q : total_q + ssrc_pkg::TotalW'(1);
            res_d.flagged = 1'b1;
            res_d.total   = total_d;
            res_d.status  = ssrc_pkg::ST_MISS;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_waddr_o = base + MAW'(top_cur);
  assign mem_wdata_o = addr_q;
  assign mem_raddr_o = base + MAW'(ring_back(top_cur, rd_n));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      flag_q      <= '0;
      for (int i = 0; i < NUM_THREADS; i++) begin
        fill_q[i] <= '0;
        top_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      flag_q      <= flag_d;
      fill_q      <= fill_d;
      top_q       <= top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    thr_q   <= thr_d;
    addr_q  <= addr_d;
    lim_q   <= lim_d;
    cmp_q   <= cmp_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

// ===== src/shadow_stack_return_checker_core.sv =====
// Top level of the shadow stack return checker: stream ports, window register,
// sequencer (ssrc_ctrl) and return address store (ssrc_stack_mem). Uses ssrc_pkg.
`default_nettype none

// Keeps one ring of return addresses per hardware thread in a single
// synchronous RAM of NUM_THREADS x STACK_DEPTH entries. A call passes from
// acceptance through the read and done states back to idle. A return also
// scans k (1..4) entries, one entry per cycle through the RAM's single read
// port, until a match or the end of the window; an empty stack scans none.
// The RAM needs no clearing after reset; items are taken as soon as reset is
// released. A finished result waits in an output register while the next
// item is accepted and worked on.
module shadow_stack_return_checker_core #(
  parameter int unsigned STACK_DEPTH = ssrc_pkg::StackDepth,
  parameter int unsigned NUM_THREADS = ssrc_pkg::NumThreads,
  parameter int unsigned ADDR_BITS   = ssrc_pkg::AddrBits
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire  [ssrc_pkg::InDataW-1:0]      s_axis_tdata_i,   // address
  input  wire  [ssrc_pkg::InUserW-1:0]      s_axis_tuser_i,   // action, thread
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  output logic [ssrc_pkg::OutDataW-1:0]     m_axis_tdata_o,   // match_depth, thread_flagged,
                                                              // mismatch_total, zero pad
  output logic [ssrc_pkg::OutUserW-1:0]     m_axis_tuser_o,   // status
  input  wire                               cfg_we_i,
  input  wire  [ssrc_pkg::WinW-1:0]         cfg_wdata_i       // search_window
);

  localparam int unsigned STORE_W = (ADDR_BITS < ssrc_pkg::AddrFieldW) ?
                                    ADDR_BITS : ssrc_pkg::AddrFieldW;
  localparam int unsigned MEM_DEPTH = NUM_THREADS * STACK_DEPTH;
  localparam int unsigned MAW = $clog2(MEM_DEPTH);
  localparam int unsigned PAD_W = ssrc_pkg::OutDataW - ssrc_pkg::TotalW
                                  - ssrc_pkg::DepthW - 1;

  logic [ssrc_pkg::WinW-1:0] win_q;
  logic [ssrc_pkg::WinW-1:0] win_eff;

  ssrc_pkg::result_t  result;
  ssrc_pkg::mem_ctl_t mem_ctl;
  logic [MAW-1:0]     mem_waddr;
  logic [MAW-1:0]     mem_raddr;
  logic [STORE_W-1:0] mem_wdata;
  logic [STORE_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= ssrc_pkg::WinReset;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (win_q == '0) begin
      win_eff = ssrc_pkg::WinW'(1);
    end else if (win_q > ssrc_pkg::WinMax) begin
      win_eff = ssrc_pkg::WinMax;
    end else begin
      win_eff = win_q;
    end
  end

  ssrc_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_THREADS (NUM_THREADS),
    .STORE_W     (STORE_W),
    .MAW         (MAW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .action_i    (s_axis_tuser_i[0]),
    .thread_i    (s_axis_tuser_i[2:1]),
    .address_i   (s_axis_tdata_i[STORE_W-1:0]),
    .win_i       (win_eff),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ssrc_stack_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (MAW),
    .DW    (STORE_W)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tuser_o = result.status;
  assign m_axis_tdata_o = {{PAD_W{1'b0}}, result.total, result.flagged, result.depth};

endmodule

`default_nettype wire

// ===== src/ssrc_checker.sv =====
// Port-level checks of the shadow stack return checker, bound to its top level.
// Uses ssrc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ssrc_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid_i,
  input wire                               s_axis_tready_o,
  input wire                               m_axis_tvalid_o,
  input wire                               m_axis_tready_i,
  input wire [ssrc_pkg::OutDataW-1:0]      m_axis_tdata_o,
  input wire [ssrc_pkg::OutUserW-1:0]      m_axis_tuser_o
);

  localparam int unsigned TOT_LO = ssrc_pkg::DepthW + 1;
  localparam int unsigned TOT_HI = TOT_LO + ssrc_pkg::TotalW - 1;

  logic                          in_acc;
  logic                          out_acc;
  logic [1:0]                    pend_q, pend_d;
  logic                          last_vld_q;
  logic [ssrc_pkg::TotalW-1:0]   last_total_q;
  logic [ssrc_pkg::TotalW-1:0]   total;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign total   = m_axis_tdata_o[TOT_HI:TOT_LO];
  assign pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      last_vld_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (out_acc) begin
        last_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) begin
      last_total_q <= total;
    end
  end

  `SSRC_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")
  `SSRC_ASSERT_IMP(a_no_extra, out_acc, pend_q != 2'd0, "result without an accepted item")
  `SSRC_ASSERT_IMP(a_total_mono, out_acc && last_vld_q, total >= last_total_q, "mismatch total went down")
  `SSRC_ASSERT_IMP(a_miss_flag, m_axis_tvalid_o && (m_axis_tuser_o == ssrc_pkg::ST_MISS), m_axis_tdata_o[ssrc_pkg::DepthW] && (total != '0), "mismatch without flag or count")

endmodule

bind shadow_stack_return_checker_core ssrc_checker u_ssrc_checker (.*);

`default_nettype wire

// ===== bench/tb_shadow_stack_return_checker_core.sv =====
// Self-checking bench for shadow_stack_return_checker_core: directed and random call/return
// items over several window settings and idle patterns, scored against a shadow-stack model.
// Depends on ssrc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_shadow_stack_return_checker_core;
  import ssrc_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned BURST_LEN   = 70;

  class ret_stack_scoreboard;
    logic [AddrBits-1:0] ring [NumThreads][StackDepth];
    int unsigned         fill [NumThreads];
    int unsigned         top_slot [NumThreads];
    logic                flagged [NumThreads];
    logic [TotalW-1:0]   miss_total;
    logic [WinW-1:0]     window;
    result_t             expected_results[$];
    int unsigned         failures;

    function new();
      for (int t = 0; t < NumThreads; t++) begin
        fill[t]     = 0;
        top_slot[t] = 0;
        flagged[t]  = 1'b0;
      end
      miss_total = '0;
      window     = WinReset;
      failures   = 0;
    endfunction

    function void set_window(logic [WinW-1:0] w);
      window = w;
    endfunction

    function int unsigned fill_level(logic [1:0] t);
      return fill[t];
    endfunction

    function logic [AddrBits-1:0] entry_at(logic [1:0] t, int unsigned d);
      return ring[t][(top_slot[t] + StackDepth - 1 - d) % StackDepth];
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function result_t predict_outcome(logic act, logic [1:0] t, logic [AddrBits-1:0] addr);
      result_t     r;
      int unsigned win;
      int unsigned lim;
      int unsigned d;
      bit          found;
      r.depth = '0;
      found   = 1'b0;
      if (act == ActCall) begin
        ring[t][top_slot[t]] = addr;
        top_slot[t] = (top_slot[t] + 1) % StackDepth;
        if (fill[t] >= StackDepth) begin
          r.status = ST_OVF;
        end else begin
          fill[t]++;
          r.status = ST_PUSH;
        end
      end else begin
        if (window == '0) win = 1;
        else if (window > WinMax) win = WinMax;
        else win = window;
        lim = (fill[t] < win) ? fill[t] : win;
        for (d = 0; d < lim; d++) begin
          if (entry_at(t, d) == addr) begin
            found = 1'b1;
            break;
          end
        end
        if (found) begin
          fill[t]     = fill[t] - (d + 1);
          top_slot[t] = (top_slot[t] + StackDepth - (d + 1)) % StackDepth;
          r.status    = (d == 0) ? ST_TOP : ST_DEEP;
          r.depth     = d[DepthW-1:0];
        end else begin
          flagged[t] = 1'b1;
          if (miss_total != '1) miss_total++;
          r.status = ST_MISS;
        end
      end
      r.flagged = flagged[t];
      r.total   = miss_total;
      return r;
    endfunction

    function void note_item(logic act, logic [1:0] t, logic [AddrBits-1:0] addr);
      expected_results.push_back(predict_outcome(act, t, addr));
    endfunction

    function void check_result(logic [2:0] st, logic [DepthW-1:0] dp, logic fl,
                               logic [TotalW-1:0] tot);
      result_t e;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: status %0d depth %0d flagged %0d total %0d",
                   st, dp, fl, tot);
      end else begin
        e = expected_results.pop_front();
        if (st !== e.status || dp !== e.depth || fl !== e.flagged || tot !== e.total) begin
          failures++;
          if (failures <= 10)
            $display("result mismatch: status %0d/%0d depth %0d/%0d flagged %0d/%0d total %0d/%0d (exp/got)",
                     e.status, st, e.depth, dp, e.flagged, fl, e.total, tot);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [InUserW-1:0]  s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [OutUserW-1:0] m_axis_tuser_o;
  logic                cfg_we_i = 1'b0;
  logic [WinW-1:0]     cfg_wdata_i = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_cycles = 0;
  ret_stack_scoreboard sb = new();

  shadow_stack_return_checker_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // tdata: match_depth [1:0], thread_flagged [2], mismatch_total [34:3]
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tuser_o, m_axis_tdata_o[1:0], m_axis_tdata_o[2],
                      m_axis_tdata_o[34:3]);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic act, input logic [1:0] thr,
                           input logic [AddrBits-1:0] addr);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = addr;
    s_axis_tuser_i  = {thr, act};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(act, thr, addr);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WinW-1:0] w);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = w;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_window(w);
  endtask

  function automatic logic [AddrBits-1:0] rand_addr();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[AddrBits-1:0];
  endfunction

  // small pool so stacks hold repeated addresses
  function automatic logic [AddrBits-1:0] pool_addr();
    return 48'h7fff_0000_0100 + 48'($urandom_range(0, 7)) * 16;
  endfunction

  task automatic random_item();
    logic               act;
    logic [1:0]         thr;
    logic [AddrBits-1:0] addr;
    int unsigned        r;
    int unsigned        d;
    thr = 2'($urandom_range(0, 3));
    r   = $urandom_range(0, 99);
    if (r < 55) begin
      act  = ActCall;
      addr = ($urandom_range(0, 99) < 30) ? pool_addr() : rand_addr();
    end else begin
      act = ActRet;
      r   = $urandom_range(0, 99);
      d   = $urandom_range(0, 4);
      if (r < 60 && sb.fill_level(thr) > d) addr = sb.entry_at(thr, d);
      else if (r < 75) addr = pool_addr();
      else addr = rand_addr();
    end
    send_item(act, thr, addr);
  endtask

  initial begin
    logic [WinW-1:0] windows [7];
    logic [1:0]      burst_thr;
    windows = '{3'd1, 3'd0, 3'd2, 3'd7, 3'd3, 3'd5, 3'd4};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, window at reset value
    send_item(ActRet, 2'd0, 48'h0000_0000_1234);   // empty stack
    send_item(ActCall, 2'd0, 48'h0);
    send_item(ActCall, 2'd0, 48'hffff_ffff_ffff);
    send_item(ActCall, 2'd0, 48'h1111);
    send_item(ActCall, 2'd0, 48'h2222);
    send_item(ActCall, 2'd0, 48'h3333);
    send_item(ActRet, 2'd0, 48'h3333);             // top
    send_item(ActRet, 2'd0, 48'hffff_ffff_ffff);   // deeper, pops through it
    send_item(ActRet, 2'd0, 48'h0);
    for (int i = 0; i < 5; i++)
      send_item(ActCall, 2'd3, 48'ha000_0000_0000 + 48'(i));
    send_item(ActRet, 2'd3, 48'ha000_0000_0000);   // below the window
    send_item(ActRet, 2'd3, 48'ha000_0000_0001);   // depth 3
    send_item(ActRet, 2'd1, 48'h5555_aaaa_5555);
    send_item(ActCall, 2'd2, 48'h5);
    send_item(ActRet, 2'd2, 48'h6);                // window deeper than stack
    send_item(ActRet, 2'd2, 48'h5);
    stop_sending();
    drain_results();

    for (int p = 0; p < 7; p++) begin
      write_window(windows[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      if (p == 2 || p == 5) begin
        // fill one stack past its depth: ring wrap and overflow
        burst_thr = 2'($urandom_range(0, 3));
        for (int i = 0; i < BURST_LEN; i++)
          send_item(ActCall, burst_thr, rand_addr());
      end
      for (int i = 0; i < 70; i++)
        random_item();
      stop_sending();
      drain_results();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
